>>> rtl/ddi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddi_pkg: shared types and helpers for the DDMMYY date interval block
// Transaction structs, date constants and small decode functions.
// ---------------------------------------------------------------------------
package ddi_pkg;

  localparam int unsigned YEAR_DAYS = 365;
  localparam int unsigned MAX_DAY   = 31;
  localparam int unsigned MAX_MONTH = 12;

  localparam logic [7:0]  ASCII_ZERO   = 8'h30;
  localparam logic [7:0]  ASCII_NINE   = 8'h39;
  // "    -1": four spaces, minus, one
  localparam logic [47:0] INVALID_TEXT = 48'h2020_2020_2D31;

  // Input transaction: two dates, first character in the top byte
  typedef struct packed {
    logic [47:0] start_date_text;
    logic [47:0] end_date_text;
    logic        lengths_ok;
  } date_pair_t;

  // Output transaction
  typedef struct packed {
    logic [15:0] interval_days;
    logic        interval_valid;
    logic [47:0] interval_text;
  } interval_t;

  // One decimal digit and what is left below it
  typedef struct packed {
    logic [3:0]  digit;
    logic [15:0] rem;
  } digit_rem_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  // Two characters read left to right up to the first non-digit
  function automatic logic [6:0] two_digits(input logic [15:0] chars);
    logic [3:0] a;
    logic [3:0] b;
    logic [6:0] v;
    a = 4'(chars[15:8] - ASCII_ZERO);
    b = 4'(chars[7:0] - ASCII_ZERO);
    v = '0;
    if (is_digit(chars[15:8])) begin
      v = 7'(a);
      if (is_digit(chars[7:0])) begin
        v = 7'(7'(a) * 7'd10 + 7'(b));
      end
    end
    return v;
  endfunction

  // Days before the first of the month: 30*(month-1) plus the month correction
  function automatic logic [8:0] month_offset(input logic [3:0] mm);
    logic [8:0] ofs;
    unique case (mm)
      4'd1:    ofs = 9'd0;
      4'd2:    ofs = 9'd31;
      4'd3:    ofs = 9'd59;
      4'd4:    ofs = 9'd90;
      4'd5:    ofs = 9'd120;
      4'd6:    ofs = 9'd151;
      4'd7:    ofs = 9'd181;
      4'd8:    ofs = 9'd212;
      4'd9:    ofs = 9'd243;
      4'd10:   ofs = 9'd273;
      4'd11:   ofs = 9'd304;
      4'd12:   ofs = 9'd334;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  // One decimal digit of rem at weight pw (parallel compares, then subtract)
  function automatic digit_rem_t digit_step(input logic [15:0] rem, input logic [15:0] pw);
    digit_rem_t r;
    logic [19:0] wide;
    wide    = {4'd0, rem};
    r.digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if (wide >= 20'(k) * {4'd0, pw}) begin
        r.digit = 4'(k);
      end
    end
    r.rem = 16'(wide - 20'(r.digit) * {4'd0, pw});
    return r;
  endfunction

endpackage

>>> rtl/ddmmyy_date_interval.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddmmyy_date_interval: day interval between two DDMMYY dates
// Eight-stage pipeline: parse, day count, subtract, decimal text.
// ---------------------------------------------------------------------------
// Takes one pair of DDMMYY dates per clock while date_stall is low and
// returns one result per pair, in order. The pipeline runs at one
// transaction per cycle while result_stall is low; each stage has its
// own valid bit and moves forward when the next stage is free, so empty
// stages fill in while the output waits. Stall on the input side follows
// from the output stall and the pipeline occupancy. A result is invalid
// (days 0, text "    -1") when a length is wrong, a day exceeds 31, a
// month is outside 1..12, or the interval is not positive. The text is
// the interval as six zero-padded ASCII digits.
module ddmmyy_date_interval
  import ddi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       date_valid,
  output logic       date_stall,
  input  date_pair_t date,
  output logic       result_valid,
  input  logic       result_stall,
  output interval_t  result
);

  localparam int unsigned NSTAGE = 8;

  // Stage valid bits and ready chain
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] rdy;

  always_comb begin
    rdy[NSTAGE] = !vld[NSTAGE] || !result_stall;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign date_stall   = !rdy[1];
  assign result_valid = vld[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= date_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: parse digits, range checks
  logic [6:0] s1_dd [2];
  logic [3:0] s1_mm [2];
  logic [6:0] s1_yy [2];
  logic       s1_ok;

  logic [6:0] p_dd [2];
  logic [6:0] p_mm [2];
  logic [6:0] p_yy [2];
  logic       p_ok;

  always_comb begin
    p_dd[0] = two_digits(date.start_date_text[47:32]);
    p_mm[0] = two_digits(date.start_date_text[31:16]);
    p_yy[0] = two_digits(date.start_date_text[15:0]);
    p_dd[1] = two_digits(date.end_date_text[47:32]);
    p_mm[1] = two_digits(date.end_date_text[31:16]);
    p_yy[1] = two_digits(date.end_date_text[15:0]);
    p_ok    = date.lengths_ok;
    for (int d = 0; d < 2; d++) begin
      if (p_dd[d] > 7'(MAX_DAY)) begin
        p_ok = 1'b0;
      end
      if (p_mm[d] == 7'd0 || p_mm[d] > 7'(MAX_MONTH)) begin
        p_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int d = 0; d < 2; d++) begin
        s1_dd[d] <= p_dd[d];
        s1_mm[d] <= p_mm[d][3:0];
        s1_yy[d] <= p_yy[d];
      end
      s1_ok <= p_ok;
    end
  end

  // Stage 2: year part (365*yy + leap terms) and month part (day + offset)
  logic [15:0] s2_ypart [2];
  logic [8:0]  s2_mpart [2];
  logic        s2_ok;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int d = 0; d < 2; d++) begin
        s2_ypart[d] <= 16'(s1_yy[d]) * 16'(YEAR_DAYS)
                     + 16'((s1_yy[d] == 7'd0) ? 7'd0 : ((s1_yy[d] - 7'd1) >> 2))
                     + 16'((s1_mm[d] > 4'd2) && (s1_yy[d][1:0] == 2'd0)
                           && (s1_yy[d] != 7'd0));
        s2_mpart[d] <= 9'(s1_dd[d]) + month_offset(s1_mm[d]);
      end
      s2_ok <= s1_ok;
    end
  end

  // Stage 3: full day counts
  logic [16:0] s3_count [2];
  logic        s3_ok;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int d = 0; d < 2; d++) begin
        s3_count[d] <= 17'(s2_ypart[d]) + 17'(s2_mpart[d]);
      end
      s3_ok <= s2_ok;
    end
  end

  // Stage 4: difference and final validity
  logic [17:0] diff;
  logic        diff_pos;
  logic [15:0] s4_val;
  logic        s4_ok;

  assign diff     = {1'b0, s3_count[1]} - {1'b0, s3_count[0]};
  assign diff_pos = !diff[17] && (diff != '0);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_ok  <= s3_ok && diff_pos;
      s4_val <= (s3_ok && diff_pos) ? diff[15:0] : '0;
    end
  end

  // Stages 5..7: one decimal digit per stage; stage 8 adds the last two
  digit_rem_t dr5;
  digit_rem_t dr6;
  digit_rem_t dr7;
  digit_rem_t dr8;

  logic        s5_ok, s6_ok, s7_ok;
  logic [15:0] s5_val, s6_val, s7_val;
  logic [15:0] s5_rem, s6_rem, s7_rem;
  logic [3:0]  s5_d4;
  logic [3:0]  s6_d4, s6_d3;
  logic [3:0]  s7_d4, s7_d3, s7_d2;

  assign dr5 = digit_step(s4_val, 16'd10000);
  assign dr6 = digit_step(s5_rem, 16'd1000);
  assign dr7 = digit_step(s6_rem, 16'd100);
  assign dr8 = digit_step(s7_rem, 16'd10);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_ok  <= s4_ok;
      s5_val <= s4_val;
      s5_rem <= dr5.rem;
      s5_d4  <= dr5.digit;
    end
    if (rdy[6]) begin
      s6_ok  <= s5_ok;
      s6_val <= s5_val;
      s6_rem <= dr6.rem;
      s6_d4  <= s5_d4;
      s6_d3  <= dr6.digit;
    end
    if (rdy[7]) begin
      s7_ok  <= s6_ok;
      s7_val <= s6_val;
      s7_rem <= dr7.rem;
      s7_d4  <= s6_d4;
      s7_d3  <= s6_d3;
      s7_d2  <= dr7.digit;
    end
  end

  // Output register: assemble the text
  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      result.interval_days  <= s7_val;
      result.interval_valid <= s7_ok;
      if (s7_ok) begin
        result.interval_text <= {ASCII_ZERO,
                                 ASCII_ZERO | 8'(s7_d4),
                                 ASCII_ZERO | 8'(s7_d3),
                                 ASCII_ZERO | 8'(s7_d2),
                                 ASCII_ZERO | 8'(dr8.digit),
                                 ASCII_ZERO | 8'(dr8.rem[3:0])};
      end else begin
        result.interval_text <= INVALID_TEXT;
      end
    end
  end

  // Checks
  a_free_output_frees_input: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !date_stall)
    else $error("input stalled while the output is free");

  a_valid_has_days: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.interval_valid |-> result.interval_days != '0)
    else $error("valid interval with zero days");

  a_invalid_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.interval_valid |->
      result.interval_days == '0 && result.interval_text == INVALID_TEXT)
    else $error("invalid result not in its fixed form");

  a_valid_text_lead: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.interval_valid |-> result.interval_text[47:40] == ASCII_ZERO)
    else $error("interval text lead digit not zero");

endmodule

>>> bench/ddmmyy_date_interval_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddmmyy_date_interval_test: self-checking bench for the date interval block
// Directed date pairs first: extremes, invalid fields, odd characters and
// leap years. Random traffic follows, mostly well-formed dates with some
// broken fields and raw noise. Every accepted pair goes through a local day
// count model, and each result transaction is checked in order. The sender
// works in bursts and the receiver stalls on a rotating pattern.
// ---------------------------------------------------------------------------
module ddmmyy_date_interval_test
  import ddi_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_PAIRS = 1530;
  localparam int DRAIN_CYCLES = 16;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       date_valid = 1'b0;
  logic       date_stall;
  date_pair_t date = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  interval_t  result;

  interval_t  pending_intervals[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  logic [8:0] stall_cycle = '0;

  ddmmyy_date_interval u_dut (
    .clk          (clk),
    .rst          (rst),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .date         (date),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Day count model
  // ---------------------------------------------------------------------

  // Two characters, read left to right until the first non-digit
  function automatic int parse_part(input logic [15:0] chars);
    int v;
    v = 0;
    if (chars[15:8] >= ASCII_ZERO && chars[15:8] <= ASCII_NINE) begin
      v = int'(chars[15:8] - ASCII_ZERO);
      if (chars[7:0] >= ASCII_ZERO && chars[7:0] <= ASCII_NINE) begin
        v = v * 10 + int'(chars[7:0] - ASCII_ZERO);
      end
    end
    return v;
  endfunction

  // Correction on top of 30 days per elapsed month
  function automatic int month_correction(input int mm);
    case (mm) inside
      2, 6, 7: return 1;
      3:       return -1;
      8:       return 2;
      9, 10:   return 3;
      11, 12:  return 4;
      default: return 0;
    endcase
  endfunction

  function automatic int day_number(input logic [47:0] txt, inout bit ok);
    int dd;
    int mm;
    int yy;
    int total;
    dd = parse_part(txt[47:32]);
    mm = parse_part(txt[31:16]);
    yy = parse_part(txt[15:0]);
    total = dd + 30 * (mm - 1);
    if (dd > 31) ok = 1'b0;
    if (mm >= 1 && mm <= 12) total += month_correction(mm);
    else ok = 1'b0;
    total += 365 * yy;
    // leap day once February is past
    if (mm > 2 && (yy % 4) == 0 && yy > 0) total += 1;
    // truncates toward zero, so year 0 adds nothing
    total += (yy - 1) / 4;
    return total;
  endfunction

  function automatic interval_t expected_interval(input date_pair_t p);
    interval_t r;
    bit        ok;
    int        diff;
    int        v;
    int        k;
    ok   = p.lengths_ok;
    diff = day_number(p.end_date_text, ok);
    diff = diff - day_number(p.start_date_text, ok);
    if (!ok || diff <= 0) begin
      r.interval_days  = '0;
      r.interval_valid = 1'b0;
      r.interval_text  = INVALID_TEXT;
    end else begin
      r.interval_days  = 16'(diff);
      r.interval_valid = 1'b1;
      v = diff;
      for (k = 0; k < 6; k++) begin
        r.interval_text[8*k +: 8] = ASCII_ZERO + 8'(v % 10);
        v = v / 10;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Monitors: record accepted input, check each output transaction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && date_valid && !date_stall) begin
      pending_intervals.push_back(expected_interval(date));
    end
  end

  always @(posedge clk) begin
    interval_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_intervals.size() == 0) begin
        $error("unexpected result transaction: days %0d text %h",
               result.interval_days, result.interval_text);
        mismatch_count++;
      end else begin
        want = pending_intervals.pop_front();
        if (result.interval_days !== want.interval_days) begin
          $error("interval_days: expected %0d, got %0d",
                 want.interval_days, result.interval_days);
          mismatch_count++;
        end
        if (result.interval_valid !== want.interval_valid) begin
          $error("interval_valid: expected %0b, got %0b",
                 want.interval_valid, result.interval_valid);
          mismatch_count++;
        end
        if (result.interval_text !== want.interval_text) begin
          $error("interval_text: expected %h, got %h",
                 want.interval_text, result.interval_text);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output stall: rotates through free-running, periodic and random modes
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 9'd1;
    case (stall_cycle[8:6]) inside
      3'd0, 3'd1: begin
        result_stall <= 1'b0;
      end
      3'd2: begin
        result_stall <= ($urandom_range(0, 1) == 0);
      end
      3'd3: begin
        result_stall <= (stall_cycle[1:0] == 2'b11);
      end
      3'd4: begin
        result_stall <= (stall_cycle[5:3] == 3'b000);
      end
      3'd5: begin
        result_stall <= ($urandom_range(0, 3) == 0);
      end
      3'd6: begin
        result_stall <= stall_cycle[0];
      end
      default: begin
        result_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // One input transaction; the sender may idle between bursts
  task automatic send_dates(input logic [47:0] first_txt, input logic [47:0] last_txt,
                            input logic lengths_ok);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
      if (gap > 0) begin
        date_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    date       <= '{start_date_text: first_txt, end_date_text: last_txt,
                    lengths_ok: lengths_ok};
    date_valid <= 1'b1;
    do @(posedge clk); while (date_stall);
  endtask

  function automatic logic [15:0] two_chars(input int v);
    return {ASCII_ZERO + 8'(v / 10), ASCII_ZERO + 8'(v % 10)};
  endfunction

  function automatic logic [47:0] make_date(input int dd, input int mm, input int yy);
    return {two_chars(dd), two_chars(mm), two_chars(yy)};
  endfunction

  function automatic logic [47:0] random_good_date();
    return make_date($urandom_range(0, 31), $urandom_range(1, 12), $urandom_range(0, 99));
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c >= ASCII_ZERO && c <= ASCII_NINE) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Break one field of an otherwise good date
  function automatic logic [47:0] broken_date();
    logic [47:0] txt;
    int          k;
    txt = random_good_date();
    case ($urandom_range(0, 3))
      0: txt[47:32] = two_chars($urandom_range(32, 99));
      1: txt[31:16] = two_chars(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99));
      2: begin
        k = $urandom_range(0, 5);
        txt[8*k +: 8] = non_digit();
      end
      default: begin
        for (k = 0; k < 6; k++) txt[8*k +: 8] = ASCII_ZERO + 8'($urandom_range(0, 9));
      end
    endcase
    return txt;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_extremes();
    send_dates("000100", "311299", 1'b1);   // day zero, widest span
    send_dates("311299", "000100", 1'b1);   // negative interval
    send_dates("150695", "150695", 1'b1);   // zero interval
    send_dates("010100", "020100", 1'b1);   // interval of one
    send_dates("311298", "010199", 1'b1);
    send_dates(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_dates(48'h0, 48'h0, 1'b0);
  endtask

  task automatic test_invalid_fields();
    send_dates("010190", "010191", 1'b0);   // wrong length
    send_dates("320190", "010191", 1'b1);   // day too large, start
    send_dates("010190", "320191", 1'b1);   // day too large, end
    send_dates("990190", "010191", 1'b1);
    send_dates("010090", "010191", 1'b1);   // month zero
    send_dates("010190", "011391", 1'b1);   // month 13
    send_dates("019990", "019991", 1'b1);
  endtask

  task automatic test_text_parsing();
    send_dates("  0100", "010100", 1'b1);   // leading blank reads as zero
    send_dates("1/0100", "310100", 1'b1);   // single digit then stop
    send_dates("0101 5", "010199", 1'b1);
    send_dates("01015A", "010199", 1'b1);
    send_dates("01 100", "010100", 1'b1);   // month reads as zero
    send_dates("011A00", "020100", 1'b1);
  endtask

  task automatic test_leap_years();
    send_dates("280204", "010304", 1'b1);   // across a leap February
    send_dates("280200", "010300", 1'b1);   // year zero has no leap day
    send_dates("010300", "010301", 1'b1);
    send_dates("010101", "010105", 1'b1);
    send_dates("311296", "010397", 1'b1);
  endtask

  task automatic test_random_traffic(input int count);
    int          n;
    int          pick;
    logic [47:0] first_txt;
    logic [47:0] last_txt;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_dates(random_good_date(), random_good_date(), $urandom_range(0, 19) != 0);
      end else if (pick < 85) begin
        first_txt = random_good_date();
        last_txt  = random_good_date();
        if ($urandom_range(0, 1) == 0) first_txt = broken_date();
        else last_txt = broken_date();
        send_dates(first_txt, last_txt, $urandom_range(0, 3) != 0);
      end else begin
        send_dates({16'($urandom), $urandom}, {16'($urandom), $urandom},
                   1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_invalid_fields();
    test_text_parsing();
    test_leap_years();
    test_random_traffic(RANDOM_PAIRS);
    date_valid <= 1'b0;
    while (pending_intervals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> ddmmyy_date_interval.f
rtl/ddi_pkg.sv
rtl/ddmmyy_date_interval.sv
bench/ddmmyy_date_interval_test.sv
